// File: rtl/indexed_framebuffer_blitter_macros.svh
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter assertion macros
// Shared property wrappers for the blitter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_FRAMEBUFFER_BLITTER_MACROS_SVH
`define INDEXED_FRAMEBUFFER_BLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ifb_pkg.sv
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter package
// Command codes, queue entry and status types, and the palette ROM.
// ----------------------------------------------------------------------------
package ifb_pkg;

  localparam int AddrMaxW  = 16;
  localparam int PalDepth  = 72;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    MODE_PLOT   = 3'd0,
    MODE_FILL   = 3'd1,
    MODE_SPRITE = 3'd2,
    MODE_ELEM   = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_FILL  = 2'd2,
    BK_READ  = 2'd3
  } back_state_e;

  // One classified command on its way from the front end to the back end.
  typedef struct packed {
    op_e                 op;
    logic                ignored;
    logic [AddrMaxW-1:0] addr;
    logic [7:0]          color;
    logic [7:0]          w_m1;
    logic [7:0]          h_m1;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  localparam logic [23:0] PALETTE [PalDepth] = '{
    24'h000000, 24'h000000, 24'hffffff, 24'hff0000,
    24'h00ff00, 24'h0000ff, 24'hffffff, 24'hffffff,
    24'h472d3c, 24'h5e3643, 24'h7a444a, 24'ha05b53,
    24'hbf7958, 24'heea160, 24'hf4cca1, 24'hb6d53c,
    24'h71aa34, 24'h397b44, 24'h3c5956, 24'h302c2e,
    24'h5a5353, 24'h7d7071, 24'ha0938e, 24'hcfc6b8,
    24'hdff6f5, 24'h8aebf1, 24'h28ccdf, 24'h3978a8,
    24'h394778, 24'h39314b, 24'h564064, 24'h8e478c,
    24'hcd6093, 24'hffaeb6, 24'hf4b41b, 24'hf47e1b,
    24'he6482e, 24'ha93b3b, 24'h827094, 24'h4f546b,
    24'h23161e, 24'h2f1b21, 24'h3d2225, 24'h502d29,
    24'h5f3c2c, 24'h775030, 24'h7a6650, 24'h5b6a1e,
    24'h38551a, 24'h1c3d22, 24'h1e2c2b, 24'h181617,
    24'h2d2929, 24'h3e3828, 24'h504947, 24'h67635c,
    24'h6f7a7a, 24'h457578, 24'h14666f, 24'h1c3c54,
    24'h1c233c, 24'h1c1825, 24'h2b2032, 24'h472346,
    24'h663049, 24'h7f575b, 24'h7a5a0d, 24'h7a3f0d,
    24'h732417, 24'h541d1d, 24'h41384a, 24'h272a35
  };

  // Entries past the end of the table read as black.
  function automatic logic [23:0] palette_rgb(input logic [7:0] idx);
    logic [23:0] rgb;
    rgb = 24'h000000;
    if (idx < 8'(PalDepth)) begin
      rgb = PALETTE[idx[6:0]];
    end
    return rgb;
  endfunction

endpackage

// File: rtl/ifb_queue.sv
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter command queue
// Two-entry FIFO that decouples command intake from frame store access.
// ----------------------------------------------------------------------------
module ifb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ifb_pkg::cmd_t cmd_o
);
  import ifb_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/ifb_front.sv
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter front end
// Accepts commands, clips them against the frame, tracks the open sprite
// and turns each command into one back-end operation.
// ----------------------------------------------------------------------------
module ifb_front #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          mode_i,
  input  logic [7:0]          x_coord_i,
  input  logic [7:0]          y_coord_i,
  input  logic [7:0]          span_width_i,
  input  logic [7:0]          span_height_i,
  input  logic [7:0]          color_i,
  input  ifb_pkg::bk_status_t status_i,
  input  logic                q_full_i,
  output logic                push_o,
  output ifb_pkg::cmd_t       cmd_o
);
  import ifb_pkg::*;

  localparam logic [8:0] FW9 = 9'(FRAME_WIDTH);
  localparam logic [8:0] FH9 = 9'(FRAME_HEIGHT);

  logic [7:0] org_x_q, org_x_d;
  logic [7:0] org_y_q, org_y_d;
  logic [7:0] size_w_q, size_w_d;
  logic [7:0] size_h_q, size_h_d;
  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic       active_q, active_d;

  logic        start_on;
  logic [8:0]  px, py;
  logic        elem_on;
  logic [7:0]  ax, ay;
  logic [16:0] row_base;
  logic [15:0] addr;
  logic [8:0]  room_w, room_h, clip_w, clip_h;

  assign in_ready_o = !q_full_i && !status_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

  assign start_on = ({1'b0, x_coord_i} < FW9) && ({1'b0, y_coord_i} < FH9);
  assign px       = {1'b0, org_x_q} + {1'b0, col_q};
  assign py       = {1'b0, org_y_q} + {1'b0, row_q};
  assign elem_on  = (px < FW9) && (py < FH9);

  // One address multiplier, shared by direct commands and sprite elements.
  assign ax       = (mode_i == MODE_ELEM) ? px[7:0] : x_coord_i;
  assign ay       = (mode_i == MODE_ELEM) ? py[7:0] : y_coord_i;
  assign row_base = {9'b0, ay} * {8'b0, FW9};
  assign addr     = row_base[15:0] + {8'b0, ax};

  assign room_w = FW9 - {1'b0, x_coord_i};
  assign room_h = FH9 - {1'b0, y_coord_i};
  assign clip_w = ({1'b0, span_width_i} > room_w) ? room_w : {1'b0, span_width_i};
  assign clip_h = ({1'b0, span_height_i} > room_h) ? room_h : {1'b0, span_height_i};

  always_comb begin
    org_x_d  = org_x_q;
    org_y_d  = org_y_q;
    size_w_d = size_w_q;
    size_h_d = size_h_q;
    col_d    = col_q;
    row_d    = row_q;
    active_d = active_q;

    cmd_o.op      = OP_NONE;
    cmd_o.ignored = 1'b0;
    cmd_o.addr    = addr;
    cmd_o.color   = color_i;
    cmd_o.w_m1    = 8'(clip_w - 9'd1);
    cmd_o.h_m1    = 8'(clip_h - 9'd1);

    case (mode_i)
      MODE_PLOT: begin
        if (start_on) begin
          cmd_o.op = OP_WRITE;
        end else begin
          cmd_o.ignored = 1'b1;
        end
      end
      MODE_FILL: begin
        if (!start_on) begin
          cmd_o.ignored = 1'b1;
        end else if (clip_w != '0 && clip_h != '0) begin
          cmd_o.op = OP_FILL;
        end
      end
      MODE_SPRITE: begin
        col_d = '0;
        row_d = '0;
        if (start_on) begin
          org_x_d  = x_coord_i;
          org_y_d  = y_coord_i;
          size_w_d = span_width_i;
          size_h_d = span_height_i;
          active_d = (span_width_i != '0) && (span_height_i != '0);
        end else begin
          active_d      = 1'b0;
          cmd_o.ignored = 1'b1;
        end
      end
      MODE_ELEM: begin
        if (!active_q) begin
          cmd_o.ignored = 1'b1;
        end else begin
          if (color_i != '0 && elem_on) begin
            cmd_o.op = OP_WRITE;
          end
          if ({1'b0, col_q} + 9'd1 >= {1'b0, size_w_q}) begin
            col_d = '0;
            if ({1'b0, row_q} + 9'd1 >= {1'b0, size_h_q}) begin
              row_d    = '0;
              active_d = 1'b0;
            end else begin
              row_d = row_q + 8'd1;
            end
          end else begin
            col_d = col_q + 8'd1;
          end
        end
      end
      MODE_READ: begin
        if (start_on) begin
          cmd_o.op = OP_READ;
        end else begin
          cmd_o.ignored = 1'b1;
        end
      end
      default: begin
        cmd_o.ignored = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      size_w_q <= '0;
      size_h_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b0;
    end else if (push_o) begin
      org_x_q  <= org_x_d;
      org_y_q  <= org_y_d;
      size_w_q <= size_w_d;
      size_h_q <= size_h_d;
      col_q    <= col_d;
      row_q    <= row_d;
      active_q <= active_d;
    end
  end

endmodule

// File: rtl/ifb_back.sv
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter back end
// Owns the frame store: clears it after reset, carries out writes, fills
// and reads, and holds the result register.
// ----------------------------------------------------------------------------
`include "indexed_framebuffer_blitter_macros.svh"

module ifb_back #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ifb_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  output ifb_pkg::bk_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [16:0]         pixels_written_o,
  output logic                ignored_o
);
  import ifb_pkg::*;

  localparam int StoreDepth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW         = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(StoreDepth - 1);
  localparam logic [AW-1:0] RowStep  = AW'(FRAME_WIDTH);

  logic [7:0] mem_q [StoreDepth];
  logic [7:0] rdata_q;

  back_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] base_q, base_d;
  logic [7:0]    col_q, col_d;
  logic [7:0]    row_q, row_d;
  logic [7:0]    w_m1_q, w_m1_d;
  logic [7:0]    h_m1_q, h_m1_d;
  logic [7:0]    fcolor_q, fcolor_d;
  logic [16:0]   fcnt_q, fcnt_d;

  logic          out_valid_q, out_valid_d;
  logic [23:0]   rgb_q, rgb_d;
  logic [16:0]   written_q, written_d;
  logic          ign_q, ign_d;

  logic          out_free;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  assign out_free          = !out_valid_q || out_ready_i;
  assign status_o.clearing = (state_q == BK_CLEAR);

  assign out_valid_o      = out_valid_q;
  assign red_o            = rgb_q[23:16];
  assign green_o          = rgb_q[15:8];
  assign blue_o           = rgb_q[7:0];
  assign pixels_written_o = written_q;
  assign ignored_o        = ign_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    base_d   = base_q;
    col_d    = col_q;
    row_d    = row_q;
    w_m1_d   = w_m1_q;
    h_m1_d   = h_m1_q;
    fcolor_d = fcolor_q;
    fcnt_d   = fcnt_q;

    out_valid_d = out_valid_q && !out_ready_i;
    rgb_d       = rgb_q;
    written_d   = written_q;
    ign_d       = ign_q;

    pop_o = 1'b0;
    we    = 1'b0;
    re    = 1'b0;
    waddr = base_q + AW'(col_q);
    raddr = cmd_i.addr[AW-1:0];
    wdata = fcolor_q;

    case (state_q)
      BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_WRITE: begin
              we          = 1'b1;
              waddr       = cmd_i.addr[AW-1:0];
              wdata       = cmd_i.color;
              out_valid_d = 1'b1;
              rgb_d       = '0;
              written_d   = 17'd1;
              ign_d       = 1'b0;
            end
            OP_FILL: begin
              base_d   = cmd_i.addr[AW-1:0];
              col_d    = '0;
              row_d    = '0;
              w_m1_d   = cmd_i.w_m1;
              h_m1_d   = cmd_i.h_m1;
              fcolor_d = cmd_i.color;
              fcnt_d   = '0;
              state_d  = BK_FILL;
            end
            OP_READ: begin
              re      = 1'b1;
              state_d = BK_READ;
            end
            default: begin
              out_valid_d = 1'b1;
              rgb_d       = '0;
              written_d   = '0;
              ign_d       = cmd_i.ignored;
            end
          endcase
        end
      end
      BK_FILL: begin
        // The result register drained when the fill was popped, so the
        // result can be loaded on the last pixel without a check.
        we     = 1'b1;
        fcnt_d = fcnt_q + 17'd1;
        if (col_q == w_m1_q) begin
          col_d  = '0;
          base_d = base_q + RowStep;
          if (row_q == h_m1_q) begin
            out_valid_d = 1'b1;
            rgb_d       = '0;
            written_d   = fcnt_q + 17'd1;
            ign_d       = 1'b0;
            state_d     = BK_IDLE;
          end else begin
            row_d = row_q + 8'd1;
          end
        end else begin
          col_d = col_q + 8'd1;
        end
      end
      BK_READ: begin
        out_valid_d = 1'b1;
        rgb_d       = palette_rgb(rdata_q);
        written_d   = '0;
        ign_d       = 1'b0;
        state_d     = BK_IDLE;
      end
      default: begin
        state_d = BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    col_q     <= col_d;
    row_q     <= row_d;
    w_m1_q    <= w_m1_d;
    h_m1_q    <= h_m1_d;
    fcolor_q  <= fcolor_d;
    fcnt_q    <= fcnt_d;
    rgb_q     <= rgb_d;
    written_q <= written_d;
    ign_q     <= ign_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  `IFB_ASSERT_IMP(a_fill_out_empty, clk_i, rst_ni, state_q == BK_FILL, !out_valid_q,
                  "result register busy during a fill")
  `IFB_ASSERT_IMP(a_read_out_empty, clk_i, rst_ni, state_q == BK_READ, !out_valid_q,
                  "result register busy while a read completes")
  `IFB_ASSERT_IMP(a_no_pop_clear, clk_i, rst_ni, state_q == BK_CLEAR, !pop_o && !out_valid_q,
                  "command taken during the clearing pass")
  `IFB_ASSERT_NXT(a_read_result, clk_i, rst_ni, pop_o && cmd_i.op == OP_READ,
                  state_q == BK_READ, "read did not move to its data phase")

endmodule

// File: rtl/indexed_framebuffer_blitter.sv
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter
// Drawing engine over a color-index frame store with a palette read path.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid_i/in_ready_o mode, x/y, span w/h, color
//  out      output     out_valid_o/out_ready_i red, green, blue, written, ignored
//
//  After reset the frame store is cleared one entry per cycle, all
//  FRAME_WIDTH * FRAME_HEIGHT entries, during which no command is accepted.
//  Plot, sprite, sprite element and rejected commands retire straight from idle;
//  a read passes through the registered frame store port and the palette ROM.
//  A fill writes one pixel per cycle, clipped width times clipped height.
//  A two-entry command queue lets intake continue while the frame store
//  port is busy or the result waits to be taken.
// ----------------------------------------------------------------------------
module indexed_framebuffer_blitter #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  x_coord_i,
  input  logic [7:0]  y_coord_i,
  input  logic [7:0]  span_width_i,
  input  logic [7:0]  span_height_i,
  input  logic [7:0]  color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [16:0] pixels_written_o,
  output logic        ignored_o
);
  import ifb_pkg::*;

  bk_status_t status;
  cmd_t       push_cmd, head_cmd;
  logic       push, pop, q_full, q_valid;

  ifb_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .span_width_i (span_width_i),
    .span_height_i(span_height_i),
    .color_i      (color_i),
    .status_i     (status),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ifb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  ifb_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .pixels_written_o(pixels_written_o),
    .ignored_o       (ignored_o)
  );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Indexed framebuffer blitter testbench
// Drives plot, fill, sprite, read and unused commands through the valid/ready
// intake, keeps a shadow copy of the frame and sprite state to predict every
// result, and checks each result transaction in order while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ifb_pkg::*;

  localparam int FRAME_W         = 128;
  localparam int FRAME_H         = 128;
  localparam int FRAME_PIXELS    = FRAME_W * FRAME_H;
  localparam int RANDOM_ITEMS    = 500;
  localparam int TAIL_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT  = 100000;
  localparam int MAX_REPORTS     = 10;
  localparam int PALETTE_ENTRIES = 72;

  // Command codes that the block must reject.
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam logic [23:0] RGB_LUT [PALETTE_ENTRIES] = '{
    24'h000000, 24'h000000, 24'hffffff, 24'hff0000,
    24'h00ff00, 24'h0000ff, 24'hffffff, 24'hffffff,
    24'h472d3c, 24'h5e3643, 24'h7a444a, 24'ha05b53,
    24'hbf7958, 24'heea160, 24'hf4cca1, 24'hb6d53c,
    24'h71aa34, 24'h397b44, 24'h3c5956, 24'h302c2e,
    24'h5a5353, 24'h7d7071, 24'ha0938e, 24'hcfc6b8,
    24'hdff6f5, 24'h8aebf1, 24'h28ccdf, 24'h3978a8,
    24'h394778, 24'h39314b, 24'h564064, 24'h8e478c,
    24'hcd6093, 24'hffaeb6, 24'hf4b41b, 24'hf47e1b,
    24'he6482e, 24'ha93b3b, 24'h827094, 24'h4f546b,
    24'h23161e, 24'h2f1b21, 24'h3d2225, 24'h502d29,
    24'h5f3c2c, 24'h775030, 24'h7a6650, 24'h5b6a1e,
    24'h38551a, 24'h1c3d22, 24'h1e2c2b, 24'h181617,
    24'h2d2929, 24'h3e3828, 24'h504947, 24'h67635c,
    24'h6f7a7a, 24'h457578, 24'h14666f, 24'h1c3c54,
    24'h1c233c, 24'h1c1825, 24'h2b2032, 24'h472346,
    24'h663049, 24'h7f575b, 24'h7a5a0d, 24'h7a3f0d,
    24'h732417, 24'h541d1d, 24'h41384a, 24'h272a35
  };

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] written;
    logic        ignored;
  } pix_result_t;

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd_mode  = '0;
  logic [7:0]  cmd_x     = '0;
  logic [7:0]  cmd_y     = '0;
  logic [7:0]  cmd_w     = '0;
  logic [7:0]  cmd_h     = '0;
  logic [7:0]  cmd_color = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  px_red;
  logic [7:0]  px_green;
  logic [7:0]  px_blue;
  logic [16:0] px_written;
  logic        px_ignored;

  // Shadow of the frame store and the sprite cursor.
  logic [7:0] frame_shadow [FRAME_PIXELS];
  int         spr_x, spr_y, spr_w, spr_h, spr_col, spr_row;
  bit         spr_open;

  pix_result_t pending_pixels [$];

  int burst_left;
  int ready_run;
  int ready_style;
  int idle_cycles;
  int err_count;
  int checked_count;
  int sent_items;
  int n_plots, n_fills, fill_pixels, n_sprite_px, n_reads, n_rejected;

  indexed_framebuffer_blitter #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (cmd_mode),
    .x_coord_i        (cmd_x),
    .y_coord_i        (cmd_y),
    .span_width_i     (cmd_w),
    .span_height_i    (cmd_h),
    .color_i          (cmd_color),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .red_o            (px_red),
    .green_o          (px_green),
    .blue_o           (px_blue),
    .pixels_written_o (px_written),
    .ignored_o        (px_ignored)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit on_frame(input int px, input int py);
    return px < FRAME_W && py < FRAME_H;
  endfunction

  // Coordinates cluster near the corners so reads land on drawn pixels and
  // fills and sprites run into the right and bottom edges.
  function automatic logic [7:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(0, 15));
    if (r < 7) return 8'($urandom_range(FRAME_W - 16, FRAME_W - 1));
    if (r < 9) return 8'($urandom_range(0, FRAME_W - 1));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_color();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, PALETTE_ENTRIES - 1));
  endfunction

  // Works out the result of one accepted command and updates the shadow state.
  task automatic predict_blit(input logic [2:0] m, input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] w, input logic [7:0] h,
                              input logic [7:0] c);
    pix_result_t r;
    int          xi, yi, cw, ch, px, py;
    logic [7:0]  idx;
    logic [23:0] rgb;
    r   = '0;
    rgb = '0;
    xi  = int'(x);
    yi  = int'(y);
    case (m)
      MODE_PLOT: begin
        if (on_frame(xi, yi)) begin
          frame_shadow[yi * FRAME_W + xi] = c;
          r.written = 17'd1;
          n_plots++;
        end else begin
          r.ignored = 1'b1;
        end
      end
      MODE_FILL: begin
        if (on_frame(xi, yi)) begin
          cw = (int'(w) > FRAME_W - xi) ? FRAME_W - xi : int'(w);
          ch = (int'(h) > FRAME_H - yi) ? FRAME_H - yi : int'(h);
          for (int row = 0; row < ch; row++) begin
            for (int col = 0; col < cw; col++) begin
              frame_shadow[(yi + row) * FRAME_W + xi + col] = c;
            end
          end
          r.written = 17'(cw * ch);
          n_fills++;
          fill_pixels += cw * ch;
        end else begin
          r.ignored = 1'b1;
        end
      end
      MODE_SPRITE: begin
        spr_col = 0;
        spr_row = 0;
        if (on_frame(xi, yi)) begin
          spr_x    = xi;
          spr_y    = yi;
          spr_w    = int'(w);
          spr_h    = int'(h);
          spr_open = (w != 8'd0) && (h != 8'd0);
        end else begin
          spr_open  = 1'b0;
          r.ignored = 1'b1;
        end
      end
      MODE_ELEM: begin
        if (!spr_open) begin
          r.ignored = 1'b1;
        end else begin
          px = spr_x + spr_col;
          py = spr_y + spr_row;
          // Transparent or off-frame elements still advance the cursor.
          if (c != 8'd0 && on_frame(px, py)) begin
            frame_shadow[py * FRAME_W + px] = c;
            r.written = 17'd1;
            n_sprite_px++;
          end
          if (spr_col + 1 >= spr_w) begin
            spr_col = 0;
            if (spr_row + 1 >= spr_h) begin
              spr_row  = 0;
              spr_open = 1'b0;
            end else begin
              spr_row++;
            end
          end else begin
            spr_col++;
          end
        end
      end
      MODE_READ: begin
        if (on_frame(xi, yi)) begin
          idx = frame_shadow[yi * FRAME_W + xi];
          rgb = (int'(idx) < PALETTE_ENTRIES) ? RGB_LUT[idx] : 24'h000000;
          n_reads++;
        end else begin
          r.ignored = 1'b1;
        end
      end
      default: r.ignored = 1'b1;
    endcase
    r.red   = rgb[23:16];
    r.green = rgb[15:8];
    r.blue  = rgb[7:0];
    if (r.ignored) n_rejected++;
    pending_pixels.push_back(r);
  endtask

  // Sends one command; the sender runs in bursts separated by random gaps.
  task automatic send_cmd(input logic [2:0] m, input logic [7:0] x, input logic [7:0] y,
                          input logic [7:0] w, input logic [7:0] h, input logic [7:0] c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(8, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid  <= 1'b1;
    cmd_mode  <= m;
    cmd_x     <= x;
    cmd_y     <= y;
    cmd_w     <= w;
    cmd_h     <= h;
    cmd_color <= c;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_blit(m, x, y, w, h, c);
    sent_items++;
    burst_left--;
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_plot_edges();
    send_cmd(MODE_PLOT, 8'd0, 8'd0, 8'hff, 8'hff, 8'd255);
    send_cmd(MODE_PLOT, 8'd127, 8'd127, 8'h00, 8'h00, 8'd8);
    send_cmd(MODE_PLOT, 8'd128, 8'd5, 8'h55, 8'haa, 8'd3);
  endtask

  task automatic test_read_palette();
    // Index 255 lies past the palette and reads black.
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(MODE_READ, 8'd127, 8'd127, 8'hff, 8'hff, 8'hff);
    send_cmd(MODE_READ, 8'd3, 8'd200, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_fill_clipping();
    send_cmd(MODE_FILL, 8'd120, 8'd120, 8'd255, 8'd255, 8'd3);
    send_cmd(MODE_FILL, 8'd10, 8'd10, 8'd0, 8'd5, 8'd9);
    send_cmd(MODE_FILL, 8'd128, 8'd0, 8'd4, 8'd4, 8'd9);
    send_cmd(MODE_READ, 8'd127, 8'd127, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_sprite_cases();
    logic [7:0] elem_colors [6] = '{8'd4, 8'd0, 8'd5, 8'd6, 8'd7, 8'd2};
    send_cmd(MODE_ELEM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd12);
    // A 3x2 sprite hanging one column past the right edge, with one
    // transparent element.
    send_cmd(MODE_SPRITE, 8'd126, 8'd10, 8'd3, 8'd2, 8'd0);
    for (int i = 0; i < 6; i++) begin
      send_cmd(MODE_ELEM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               elem_colors[i]);
    end
    send_cmd(MODE_ELEM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd12);
    send_cmd(MODE_SPRITE, 8'd5, 8'd5, 8'd0, 8'd4, 8'd0);
    send_cmd(MODE_ELEM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd12);
    // Restart an open sprite, then close it with an off-frame start.
    send_cmd(MODE_SPRITE, 8'd1, 8'd1, 8'd2, 8'd2, 8'd0);
    send_cmd(MODE_ELEM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9);
    send_cmd(MODE_SPRITE, 8'd1, 8'd1, 8'd2, 8'd2, 8'd0);
    send_cmd(MODE_SPRITE, 8'd200, 8'd1, 8'd2, 8'd2, 8'd0);
    send_cmd(MODE_ELEM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9);
  endtask

  task automatic test_unused_modes();
    send_cmd(MODE_SPARE_5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_cmd(MODE_SPARE_6, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2);
    send_cmd(MODE_SPARE_7, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3);
  endtask

  // Mostly complete sprite sequences and small drawings near the corners,
  // with truncated sprites, stray elements and random noise mixed in.
  task automatic test_random_traffic(input int n_items);
    int         goal, pick, sw, sh, total;
    logic [2:0] m;
    logic [7:0] c;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        sw = $urandom_range(1, 5);
        sh = $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0) begin
          sw = $urandom_range(1, 255);
          sh = $urandom_range(1, 2);
        end else if ($urandom_range(0, 19) == 0) begin
          sw = 0;
        end
        send_cmd(MODE_SPRITE, pick_coord(), pick_coord(), 8'(sw), 8'(sh), 8'($urandom));
        total = sw * sh;
        if (total > 0 && $urandom_range(0, 6) == 0) total = $urandom_range(0, total - 1);
        // A wide sprite near the end of the budget is cut short.
        if (total > goal - sent_items) total = goal - sent_items;
        for (int i = 0; i < total; i++) begin
          c = ($urandom_range(0, 3) == 0) ? 8'd0 : pick_color();
          send_cmd(MODE_ELEM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), c);
        end
      end else if (pick < 55) begin
        send_cmd(MODE_PLOT, pick_coord(), pick_coord(), 8'($urandom), 8'($urandom),
                 pick_color());
      end else if (pick < 67) begin
        // Full-frame fills are slow, so only a rare one is that large.
        if ($urandom_range(0, 29) == 0) begin
          sw = 255;
          sh = 255;
        end else begin
          sw = $urandom_range(0, 12);
          sh = $urandom_range(0, 12);
        end
        send_cmd(MODE_FILL, pick_coord(), pick_coord(), 8'(sw), 8'(sh), pick_color());
      end else if (pick < 87) begin
        send_cmd(MODE_READ, pick_coord(), pick_coord(), 8'($urandom), 8'($urandom),
                 8'($urandom));
      end else begin
        m = 3'($urandom_range(0, 7));
        if (m == MODE_FILL) m = MODE_ELEM;
        send_cmd(m, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Receiver stall pattern: runs of always ready, light, heavy and periodic stalls.
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      ready_style = $urandom_range(0, 3);
      ready_run   = $urandom_range(10, 80);
    end
    ready_run--;
    case (ready_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (ready_run % 7) < 2;
    endcase
  end

  always @(posedge clk_i) begin
    pix_result_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected result transaction: rgb %02h%02h%02h written %0d ignored %0b",
                   px_red, px_green, px_blue, px_written, px_ignored);
        end
      end else begin
        exp_px = pending_pixels.pop_front();
        checked_count++;
        if (px_red !== exp_px.red || px_green !== exp_px.green || px_blue !== exp_px.blue ||
            px_written !== exp_px.written || px_ignored !== exp_px.ignored) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("mismatch on result %0d: expected rgb %02h%02h%02h written %0d ignored %0b",
                     checked_count, exp_px.red, exp_px.green, exp_px.blue, exp_px.written,
                     exp_px.ignored);
            $display("  got rgb %02h%02h%02h written %0d ignored %0b",
                     px_red, px_green, px_blue, px_written, px_ignored);
          end
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < FRAME_PIXELS; i++) frame_shadow[i] = 8'd0;
    spr_x    = 0;
    spr_y    = 0;
    spr_w    = 0;
    spr_h    = 0;
    spr_col  = 0;
    spr_row  = 0;
    spr_open = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    test_plot_edges();
    test_read_palette();
    test_fill_clipping();
    test_sprite_cases();
    test_unused_modes();
    drain_results();
    test_random_traffic(RANDOM_ITEMS / 2);
    drain_results();
    test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d plots, %0d fills covering %0d pixels,",
             checked_count, n_plots, n_fills, fill_pixels);
    $display("  %0d sprite pixels drawn, %0d palette reads, %0d rejected commands.",
             n_sprite_px, n_reads, n_rejected);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
